// ----- hw/rtl/bma_pkg.sv -----
`timescale 1ns / 1ps

package bma_pkg;

   // window geometry
   localparam int WINDOW_DEPTH = 256;
   localparam int SAMPLE_W     = 31;
   localparam int IDX_W        = $clog2(WINDOW_DEPTH);
   localparam int TOTAL_W      = SAMPLE_W + IDX_W;
   localparam int DIV_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int STEP_W       = $clog2(SAMPLE_W);

   // commands from the controller to the datapath
   typedef struct packed {
      logic update;   // replace oldest slot, adjust total, load divider
      logic step;     // one quotient bit
      logic load;     // move result into the output register
   } bma_cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic sample_zero;
   } bma_status_type;

endpackage

// ----- hw/rtl/bma_ram.sv -----
`timescale 1ns / 1ps

module bma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bma_ctrl.sv -----
`timescale 1ns / 1ps

module bma_ctrl
   import bma_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   input  bma_status_type status,
   output bma_cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_DIVIDE = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cmd.update = 1'b0;
      cmd.step   = 1'b0;
      cmd.load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            step_in = '0;
            if (status.sample_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd.update = 1'b1;
               state_in   = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(SAMPLE_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- hw/rtl/bma_dp.sv -----
`timescale 1ns / 1ps

module bma_dp
   import bma_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                capture,
   input  logic [SAMPLE_W-1:0] req_rate_sample,
   input  bma_cmd_type         cmd,
   output bma_status_type      status,
   output logic [SAMPLE_W-1:0] rsp_average_rate,
   output logic                rsp_accepted
);

   logic [SAMPLE_W-1:0] sample_ff;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                full_ff, full_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;
   logic [SAMPLE_W-1:0] held_ff, held_in;
   logic [DIV_W-1:0]    divisor_ff, divisor_in;
   logic [DIV_W-1:0]    rem_ff, rem_in;
   logic [SAMPLE_W-1:0] quo_ff, quo_in;
   logic [SAMPLE_W-1:0] avg_ff, avg_in;
   logic                acc_ff, acc_in;
   logic [SAMPLE_W-1:0] ring_rdata;
   logic [SAMPLE_W-1:0] oldest;
   logic [TOTAL_W-1:0]  total_new;
   logic [DIV_W:0]      trial;
   logic                fits;
   logic                last_slot;

   // read address sits on the write index while idle, so the oldest
   // sample is ready in the cycle after capture
   bma_ram #(
      .WIDTH(SAMPLE_W),
      .DEPTH(WINDOW_DEPTH)
   ) u_ring (
      .clock  (clock),
      .wr_en  (cmd.update),
      .wr_addr(idx_ff),
      .wr_data(sample_ff),
      .rd_addr(idx_ff),
      .rd_data(ring_rdata)
   );

   // slots are filled in order, so a slot is still empty until the first wrap
   assign oldest    = full_ff ? ring_rdata : '0;
   assign total_new = total_ff - TOTAL_W'(oldest) + TOTAL_W'(sample_ff);
   assign last_slot = (idx_ff == IDX_W'(WINDOW_DEPTH - 1));

   assign trial = {rem_ff, quo_ff[SAMPLE_W-1]};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      idx_in     = idx_ff;
      full_in    = full_ff;
      total_in   = total_ff;
      held_in    = held_ff;
      divisor_in = divisor_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      avg_in     = avg_ff;
      acc_in     = acc_ff;
      if (cmd.update) begin
         total_in   = total_new;
         divisor_in = full_ff ? DIV_W'(WINDOW_DEPTH) : (DIV_W'(idx_ff) + 1'b1);
         // quotient fits in the sample width, so the upper bits start below
         // the divisor and only the low bits need steps
         rem_in     = DIV_W'(total_new[TOTAL_W-1:SAMPLE_W]);
         quo_in     = total_new[SAMPLE_W-1:0];
         idx_in     = last_slot ? '0 : idx_ff + 1'b1;
         full_in    = full_ff || last_slot;
      end
      if (cmd.step) begin
         rem_in = fits ? DIV_W'(trial - {1'b0, divisor_ff}) : trial[DIV_W-1:0];
         quo_in = {quo_ff[SAMPLE_W-2:0], fits};
      end
      if (cmd.load) begin
         if (sample_ff == '0) begin
            avg_in = held_ff;
            acc_in = 1'b0;
         end else begin
            avg_in  = quo_ff;
            held_in = quo_ff;
            acc_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         full_ff  <= 1'b0;
         total_ff <= '0;
         held_ff  <= '0;
      end else begin
         idx_ff   <= idx_in;
         full_ff  <= full_in;
         total_ff <= total_in;
         held_ff  <= held_in;
      end
      if (capture) begin
         sample_ff <= req_rate_sample;
      end
      divisor_ff <= divisor_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      avg_ff     <= avg_in;
      acc_ff     <= acc_in;
   end

   assign status.sample_zero = (sample_ff == '0);
   assign rsp_average_rate   = avg_ff;
   assign rsp_accepted       = acc_ff;

endmodule

// ----- hw/rtl/bitrate_moving_average.sv -----
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_rate_sample[30:0]
// rsp       out        rsp_valid/rsp_stall  rsp_average_rate[30:0], rsp_accepted
//
// nonzero word: oldest slot read at the accept edge, update state writes ring and total,
// 31 restoring divider steps, done state loads the output; result valid in the next cycle
// zero word: update and divide skipped, done state loads the held average, state untouched
// input reopens right after the load, so one word is in flight; the load waits on rsp_stall
// reset clears index, fill flag, total and held average; unfilled slots read as zero
// a stalled result holds the output while the next word is taken; its quotient waits

module bitrate_moving_average
   import bma_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [SAMPLE_W-1:0] req_rate_sample,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [SAMPLE_W-1:0] rsp_average_rate,
   output logic                rsp_accepted
);

   bma_cmd_type    cmd;
   bma_status_type status;
   logic           req_take;

   // a word is taken only while the controller sits idle
   assign req_take = req_valid && !req_stall;

   // sequencer: owns the handshakes and the divider step count
   bma_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .status   (status),
      .cmd      (cmd)
   );

   // ring, running total, divider and output register
   bma_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .capture         (req_take),
      .req_rate_sample (req_rate_sample),
      .cmd             (cmd),
      .status          (status),
      .rsp_average_rate(rsp_average_rate),
      .rsp_accepted    (rsp_accepted)
   );

`ifndef SYNTHESIS
   // one word in flight: input closes right after an accept
   a_accept_closes: assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("input still open after accept");

   // datapath commands never overlap
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.update, cmd.step, cmd.load}))
      else $error("overlapping datapath commands");

   // a load always presents a result the next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> rsp_valid)
      else $error("loaded result not presented");

   // no ring update or divide step while the input is open
   a_busy_stall: assert property (@(posedge clock) disable iff (reset)
      (cmd.update || cmd.step) |-> req_stall)
      else $error("datapath busy while input open");
`endif

endmodule
